// ----- sv/tmaws_pkg.sv -----
package tmaws_pkg;

  // Field width of samples, averages and thresholds
  localparam int SAMPLE_W = 14;

  // Default averaging window length
  localparam int WINDOW_DEF = 10;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ON_LOWER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ON_UPPER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_LOWER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_UPPER = 2'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Threshold reset values
  localparam sample_t ON_LOWER_RST  = 14'sd600;
  localparam sample_t ON_UPPER_RST  = 14'sd977;
  localparam sample_t OFF_LOWER_RST = -14'sd1000;
  localparam sample_t OFF_UPPER_RST = -14'sd600;

endpackage

// ----- sv/tilt_moving_average_window_switch.sv -----
// Tilt moving-average window switch. Each input word carries one signed 14-bit
// Y-axis tilt sample in milli-g (in_tdata[13:0]). The block keeps the last
// WINDOW samples in a ring (all zero after reset, so the zeros count as samples
// during warm-up) and a running sum. Every sample gives exactly one output word:
// the window average truncated toward zero in out_tdata[13:0] and the motor flag
// in out_tdata[14]. The flag is set when the exact average lies strictly inside
// the on window (on_lower, on_upper), cleared when it lies strictly inside the
// off window (off_lower, off_upper), and held otherwise; the on window wins
// when both hold. Compares are exact, done on the sum against threshold times
// WINDOW. Throughput is one word per clock unless the output stalls. Stage 1
// holds the running-sum loop (ring read, subtract oldest, add newest); the
// compares and the reciprocal-multiply divide sit in stage 2, ahead of the
// output register, so an accepted word passes stage 1, then the output register.
// Write the four threshold registers through cfg_we/cfg_index/cfg_data while
// no word is in flight.
module tilt_moving_average_window_switch #(
  parameter int WINDOW = tmaws_pkg::WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream; tdata: [13:0] tilt_sample, [15:14] zero
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [15:0]                      in_tdata,
  // Output stream; tdata: [13:0] tilt_average, [14] motor_run, [15] zero
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [15:0]                      out_tdata,
  // Configuration write port
  input  logic                             cfg_we,
  input  logic [tmaws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmaws_pkg::SAMPLE_W-1:0]   cfg_data
);

  localparam int SW    = tmaws_pkg::SAMPLE_W;
  localparam int LOG_W = $clog2(WINDOW);
  // Sum range is +-2^(SW-1) * WINDOW
  localparam int SUM_W = SW + LOG_W;
  localparam int POS_W = (LOG_W < 1) ? 1 : LOG_W;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

  // Exact floor division of a SUM_W-bit magnitude by WINDOW:
  // q = (mag * RECIP) >> SHIFT, RECIP = ceil(2^SHIFT / WINDOW)
  localparam int    SHIFT   = SUM_W + LOG_W;
  localparam int    RECIP_W = SUM_W + 1;
  localparam longint RECIP  = ((64'sd1 <<< SHIFT) + WINDOW - 1) / WINDOW;
  localparam int    PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

  typedef logic signed [SUM_W-1:0] sum_t;

  function automatic sum_t scale_thr(input tmaws_pkg::sample_t thr);
    return SUM_W'(thr) * SUM_W'(WINDOW);
  endfunction

  // Threshold registers
  tmaws_pkg::sample_t on_lower_r, on_upper_r, off_lower_r, off_upper_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_lower_r  <= tmaws_pkg::ON_LOWER_RST;
      on_upper_r  <= tmaws_pkg::ON_UPPER_RST;
      off_lower_r <= tmaws_pkg::OFF_LOWER_RST;
      off_upper_r <= tmaws_pkg::OFF_UPPER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tmaws_pkg::REG_ON_LOWER:  on_lower_r  <= cfg_data;
        tmaws_pkg::REG_ON_UPPER:  on_upper_r  <= cfg_data;
        tmaws_pkg::REG_OFF_LOWER: off_lower_r <= cfg_data;
        tmaws_pkg::REG_OFF_UPPER: off_upper_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: ring and running sum
  // ---------------------------------------------------------------------------
  tmaws_pkg::sample_t ring_r [WINDOW];
  sum_t               sum_r, sum_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               s1_valid_r;
  sum_t               s1_sum_r;

  logic               in_acc;
  logic               out_adv;
  tmaws_pkg::sample_t sample;

  assign sample  = tmaws_pkg::sample_t'(in_tdata[SW-1:0]);
  // Stage 1 word moves on when the output register is empty or being drained
  assign out_adv   = s1_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !s1_valid_r || out_adv;
  assign in_acc    = in_tvalid && in_tready;

  // Drop the oldest sample, add the newest
  assign sum_nxt = sum_r - SUM_W'(ring_r[pos_r]) + SUM_W'(sample);
  assign pos_nxt = (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) ring_r[i] <= '0;
      sum_r      <= '0;
      pos_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        ring_r[pos_r] <= sample;
        sum_r         <= sum_nxt;
        pos_r         <= pos_nxt;
        s1_valid_r    <= 1'b1;
      end else if (out_adv) begin
        s1_valid_r    <= 1'b0;
      end
    end
  end

  // Snapshot of the sum that goes with the stage 1 word
  always_ff @(posedge clk) begin
    if (in_acc) s1_sum_r <= sum_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: window compares, divide, output register
  // ---------------------------------------------------------------------------
  sum_t               on_lo_w, on_hi_w, off_lo_w, off_hi_w;
  logic               on_hit, off_hit;
  logic               motor_flag_r, motor_flag_nxt;
  logic               sum_neg;
  logic [SUM_W-1:0]   sum_mag;
  logic [PROD_W-1:0]  prod;
  logic [SW-1:0]      quot;
  tmaws_pkg::sample_t avg_nxt;
  tmaws_pkg::sample_t out_avg_r;
  logic               out_valid_r;

  assign on_lo_w  = scale_thr(on_lower_r);
  assign on_hi_w  = scale_thr(on_upper_r);
  assign off_lo_w = scale_thr(off_lower_r);
  assign off_hi_w = scale_thr(off_upper_r);

  assign on_hit  = (s1_sum_r > on_lo_w)  && (s1_sum_r < on_hi_w);
  assign off_hit = (s1_sum_r > off_lo_w) && (s1_sum_r < off_hi_w);

  // On window wins; outside both windows hold the flag
  always_comb begin
    motor_flag_nxt = motor_flag_r;
    if (on_hit) begin
      motor_flag_nxt = 1'b1;
    end else if (off_hit) begin
      motor_flag_nxt = 1'b0;
    end
  end

  // Truncate toward zero: divide the magnitude, then restore the sign
  assign sum_neg = s1_sum_r[SUM_W-1];
  assign sum_mag = sum_neg ? SUM_W'(-s1_sum_r) : SUM_W'(s1_sum_r);
  assign prod    = PROD_W'(sum_mag) * PROD_W'(RECIP_V);
  assign quot    = prod[SHIFT +: SW];
  assign avg_nxt = sum_neg ? tmaws_pkg::sample_t'(-quot) : tmaws_pkg::sample_t'(quot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_flag_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_adv) begin
        motor_flag_r <= motor_flag_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) out_avg_r <= avg_nxt;
  end

  assign out_tvalid = out_valid_r;
  // The flag register is updated only as a word enters the output register,
  // so it always matches the word on display
  assign out_tdata  = {1'b0, motor_flag_r, out_avg_r};

`ifndef ASSERT_OFF
  // Write position never leaves the ring
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("write position past end of ring");

  // Input stalls only when both stages are full and the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a full pipeline");

  // A blocked stage 1 word keeps its sum
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_adv) |=> (s1_valid_r && $stable(s1_sum_r)))
    else $error("stage 1 word lost or changed while blocked");

  // A sum inside the on window turns the motor on
  a_on_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (out_adv && on_hit) |=> motor_flag_r)
    else $error("motor flag not set inside on window");

  // A sum in neither window holds the flag
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_adv && !on_hit && !off_hit) |=> $stable(motor_flag_r))
    else $error("motor flag changed outside both windows");
`endif

endmodule

// ----- verif/testbench.sv -----
module testbench;
  import tmaws_pkg::*;

  localparam int WIN        = WINDOW_DEF;
  localparam int CYCLE_CAP  = 200000;
  localparam int LONG_HOLD  = 300;
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 100;

  // One output word split into its fields
  typedef struct packed {
    sample_t tilt_average;
    logic    motor_run;
  } tilt_result_t;

  // Tracks the ring, running sum and motor flag, and holds the averages and
  // flags still owed by the block, oldest first.
  class tilt_scoreboard;
    int           ring[WIN];
    int           window_sum;
    int           wr_slot;
    logic         motor;
    int           thr[4];
    tilt_result_t owed_q[$];
    int           errors;

    function new();
      foreach (ring[i]) ring[i] = 0;
      window_sum = 0;
      wr_slot    = 0;
      motor      = 1'b0;
      thr[REG_ON_LOWER]  = ON_LOWER_RST;
      thr[REG_ON_UPPER]  = ON_UPPER_RST;
      thr[REG_OFF_LOWER] = OFF_LOWER_RST;
      thr[REG_OFF_UPPER] = OFF_UPPER_RST;
      errors = 0;
    endfunction

    function void set_threshold(logic [CFG_IDX_W-1:0] idx, sample_t val);
      thr[idx] = val;
    endfunction

    // Advance the window by one accepted sample and queue the word it owes
    function void note_sample(sample_t s);
      tilt_result_t r;
      window_sum    = window_sum - ring[wr_slot] + int'(s);
      ring[wr_slot] = s;
      wr_slot       = (wr_slot == WIN - 1) ? 0 : wr_slot + 1;
      // Exact compares on the sum; the on window wins when both hold it
      if (window_sum > thr[REG_ON_LOWER] * WIN && window_sum < thr[REG_ON_UPPER] * WIN)
        motor = 1'b1;
      else if (window_sum > thr[REG_OFF_LOWER] * WIN &&
               window_sum < thr[REG_OFF_UPPER] * WIN)
        motor = 1'b0;
      r.tilt_average = sample_t'(window_sum / WIN);
      r.motor_run    = motor;
      owed_q.push_back(r);
    endfunction

    function void check_word(logic [15:0] word);
      tilt_result_t want;
      sample_t      got_avg;
      logic         got_motor;
      got_avg   = word[13:0];
      got_motor = word[14];
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected output word: expected none, actual avg %0d motor %0b",
                 $time, got_avg, got_motor);
        return;
      end
      want = owed_q.pop_front();
      if (got_avg !== want.tilt_average) begin
        errors++;
        $display("%0t: tilt_average mismatch: expected %0d, actual %0d",
                 $time, want.tilt_average, got_avg);
      end
      if (got_motor !== want.motor_run) begin
        errors++;
        $display("%0t: motor_run mismatch: expected %0b, actual %0b",
                 $time, want.motor_run, got_motor);
      end
    endfunction

    function int owed();
      return owed_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [15:0]          in_tdata;   // [13:0] tilt_sample, [15:14] zero
  logic                 out_tvalid;
  logic                 out_tready;
  logic [15:0]          out_tdata;  // [13:0] tilt_average, [14] motor_run, [15] zero
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  sample_t              cfg_data;

  tilt_scoreboard sb;
  bit             tx_idle_on;
  bit             rx_idle_on;
  int             rx_long_hold;
  int             cycle_count;

  tilt_moving_average_window_switch uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: end the run if the block hangs or the flow never drains
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("tilt_moving_average_window_switch verification failed");
      $finish;
    end
  end

  // Saturate to the signed 14-bit sample range
  function automatic sample_t clamp14(int v);
    if (v > 8191) return 14'sd8191;
    if (v < -8192) return -14'sd8192;
    return sample_t'(v);
  endfunction

  // Offer one sample until the block takes it; the pad bits above the field
  // are expected to be ignored, so they carry whatever the caller gives.
  task automatic push_sample(sample_t s, logic [1:0] pad);
    in_tvalid <= 1'b1;
    in_tdata  <= {pad, s};
    do @(posedge clk); while (!in_tready);
    sb.note_sample(s);
  endtask

  // Random sender gap between words; valid drops only for the gap
  task automatic sender_gap();
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every owed word has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.owed() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, sample_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_threshold(idx, val);
  endtask

  task automatic write_windows(sample_t on_lo, sample_t on_hi, sample_t off_lo, sample_t off_hi);
    write_reg(REG_ON_LOWER, on_lo);
    write_reg(REG_ON_UPPER, on_hi);
    write_reg(REG_OFF_LOWER, off_lo);
    write_reg(REG_OFF_UPPER, off_hi);
    cfg_we <= 1'b0;
  endtask

  // Pick a bound pair for one window: full range, equal (empty), a random pair
  // that may be crossed, or a plain open interval of random width.
  task automatic pick_window(output sample_t lo, output sample_t hi);
    int base;
    case ($urandom_range(0, 7))
      0: begin
        lo = -14'sd8192;
        hi = 14'sd8191;
      end
      1: begin
        lo = sample_t'($urandom);
        hi = lo;
      end
      2: begin
        lo = sample_t'($urandom);
        hi = sample_t'($urandom);
      end
      default: begin
        base = int'($urandom_range(0, 12000)) - 8192;
        lo   = clamp14(base);
        hi   = clamp14(base + int'($urandom_range(1, 3000)));
      end
    endcase
  endtask

  // Receiver: random ready bursts, a long hold on request, and a check of
  // every word taken.
  initial begin : receiver
    int   gap_left;
    logic ready;
    gap_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_long_hold > 0) begin
        ready = 1'b0;
        rx_long_hold--;
      end else if (gap_left > 0) begin
        ready = 1'b0;
        gap_left--;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        ready    = 1'b0;
        gap_left = $urandom_range(1, 19) - 1;
      end else begin
        ready = 1'b1;
      end
      out_tready <= ready;
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_word(out_tdata);
    end
  end

  initial begin : stimulus
    int      run_left;
    int      level;
    int      noise;
    int      v;
    sample_t s;
    sample_t on_lo;
    sample_t on_hi;
    sample_t off_lo;
    sample_t off_hi;

    sb           = new();
    tx_idle_on   = 1'b0;
    rx_idle_on   = 1'b0;
    rx_long_hold = 0;
    cycle_count  <= 0;
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    out_tready   <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_ON_LOWER;
    cfg_data     <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Warm-up under reset thresholds: the zero entries still count, so the
    // first full-scale sample already lands inside the on window. The pad
    // bits above the field vary and must be ignored.
    push_sample(14'sd8191, 2'b00);
    push_sample(-14'sd8192, 2'b11);
    push_sample(-14'sd8000, 2'b10);
    push_sample(14'sd0, 2'b01);
    push_sample(-14'sd1, 2'b11);
    push_sample(14'sd1, 2'b00);
    drain();

    // Both windows span everything: the on window wins
    write_windows(-14'sd8192, 14'sd8191, -14'sd8192, 14'sd8191);
    push_sample(-14'sd5000, 2'b00);
    push_sample(14'sd3000, 2'b00);
    drain();

    // Equal bounds and crossed bounds: neither window acts, flag holds
    write_windows(14'sd100, 14'sd100, 14'sd8191, -14'sd8192);
    push_sample(14'sd8191, 2'b00);
    push_sample(-14'sd8192, 2'b00);
    push_sample(14'sd8191, 2'b00);
    drain();

    // One-unit windows: only sums strictly between the scaled bounds act
    write_windows(14'sd0, 14'sd1, -14'sd1, 14'sd0);
    push_sample(14'sd5, 2'b00);
    push_sample(-14'sd5, 2'b00);
    push_sample(14'sd9, 2'b00);
    push_sample(-14'sd9, 2'b00);
    drain();

    // Random phases: runs of samples around a level (mostly at a window
    // center or a bound) with noise, plus full-range and extreme words.
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        write_windows(ON_LOWER_RST, ON_UPPER_RST, OFF_LOWER_RST, OFF_UPPER_RST);
      end else begin
        pick_window(on_lo, on_hi);
        pick_window(off_lo, off_hi);
        write_windows(on_lo, on_hi, off_lo, off_hi);
      end
      // Last phase runs flat out; the long-hold phase keeps the sender busy
      tx_idle_on = (p != PHASES - 1) && (p != 2);
      rx_idle_on = (p != PHASES - 1);
      if (p == 2) rx_long_hold = LONG_HOLD;
      run_left = 0;
      level    = 0;
      noise    = 0;
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (run_left == 0) begin
          run_left = $urandom_range(5, 30);
          noise    = $urandom_range(0, 300);
          case ($urandom_range(0, 3))
            0: level = (sb.thr[REG_ON_LOWER] + sb.thr[REG_ON_UPPER]) / 2;
            1: level = (sb.thr[REG_OFF_LOWER] + sb.thr[REG_OFF_UPPER]) / 2;
            2: level = sb.thr[$urandom_range(0, 3)];
            default: level = int'($urandom_range(0, 16383)) - 8192;
          endcase
        end
        run_left--;
        case ($urandom_range(0, 9))
          0, 1: s = sample_t'($urandom);
          2: begin
            case ($urandom_range(0, 3))
              0: s = 14'sd8191;
              1: s = -14'sd8192;
              2: s = 14'sd0;
              default: s = -14'sd1;
            endcase
          end
          default: begin
            v = level + int'($urandom_range(0, 2 * noise)) - noise;
            s = clamp14(v);
          end
        endcase
        push_sample(s, 2'($urandom));
        // Hold the sender once mid-run until every owed word is back
        if (p == 4 && i == PHASE_LEN / 2) drain();
        else sender_gap();
      end
      drain();
    end

    // Every owed word is back; keep the clock running so that any stray output
    // shows before the verdict.
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.owed() == 0) begin
      $display("tilt_moving_average_window_switch verification clean");
    end else begin
      $display("tilt_moving_average_window_switch verification failed");
    end
    $finish;
  end

endmodule
